/* src/psrl_pkg.sv */
// Package with the shared constants and widths of the request rate limiter.
`timescale 1ns / 1ps

package psrl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int SECOND_W      = 32;
    localparam int COUNT_W       = 16;
    localparam int THRESHOLD_W   = 16;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(20);
    localparam logic [COUNT_W-1:0]     COUNT_MAX       = '1;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [SECOND_W-1:0] t_second;
    typedef logic [COUNT_W-1:0]  t_count;

endpackage

/* src/psrl_if.sv */
// Handshake interfaces for the request and result channels of the rate limiter.
`timescale 1ns / 1ps

interface psrl_in_if import psrl_pkg::*; ();
    logic    valid;
    logic    ready;
    t_addr   source_address;
    t_second now_second;

    modport source (output valid, output source_address, output now_second, input ready);
    modport sink   (input valid, input source_address, input now_second, output ready);
endinterface

interface psrl_out_if;
    logic valid;
    logic ready;
    logic banned;
    logic tracked;

    modport source (output valid, output banned, output tracked, input ready);
    modport sink   (input valid, input banned, input tracked, output ready);
endinterface

/* src/per_source_request_rate_limiter_core.sv */
// Per-source fixed-window request rate limiter with a fully parallel source table.
//
// A request word on i_req carries a source address and the current second. Every
// accepted word produces exactly one result word on o_rsp with banned and tracked.
// The ban threshold is to be written through i_cfg_we and i_cfg_wdata by the user only
// while the block is idle; the block does not enforce this. An accepted request sits in
// an input register; when the output allows, all table entries compare its address in
// parallel, update the matching or next free entry and load the result register.
// A new request can be accepted in every cycle while o_rsp is ready, one word per cycle.
// The state of the table is written in the same cycle that the result is registered,
// so back-to-back requests of the same source see each other's updates.
// If the receiver stalls, the result register holds its word and the input register
// fills; the request channel stops only when both are occupied.
// Reset clears the table, the fill level and both handshake stages, and sets the
// threshold to 20. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module per_source_request_rate_limiter_core import psrl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    psrl_in_if.sink                i_req,
    psrl_out_if.source             o_rsp,
    input  logic                   i_cfg_we,
    input  logic [THRESHOLD_W-1:0] i_cfg_wdata
);

    logic [THRESHOLD_W-1:0]   r_ban_threshold;
    logic                     r_in_valid;
    t_addr                    r_in_addr;
    t_second                  r_in_second;
    logic                     r_out_valid;
    logic                     r_out_banned;
    logic                     r_out_tracked;
    logic [FILL_W-1:0]        r_fill;
    logic [TABLE_ENTRIES-1:0] r_slot_valid;
    t_addr                    r_slot_address [TABLE_ENTRIES];
    t_count                   r_slot_count   [TABLE_ENTRIES];
    t_second                  r_slot_second  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_slot_banned;

    logic                     advance;
    logic [TABLE_ENTRIES-1:0] hit;
    logic [TABLE_ENTRIES-1:0] same_second;
    logic [TABLE_ENTRIES-1:0] n_banned;
    t_count                   n_count [TABLE_ENTRIES];
    logic                     any_hit;
    logic                     full;
    logic                     insert;
    logic                     n_out_banned;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.banned  = r_out_banned;
    assign o_rsp.tracked = r_out_tracked;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit[i]         = r_slot_valid[i] && (r_slot_address[i] == r_in_addr);
            same_second[i] = r_slot_second[i] == r_in_second;
            n_count[i]     = (r_slot_count[i] != COUNT_MAX) ? r_slot_count[i] + 1'b1
                                                            : r_slot_count[i];
            n_banned[i]    = same_second[i] &&
                             (r_slot_banned[i] || (n_count[i] >= r_ban_threshold));
        end
        any_hit      = |hit;
        full         = r_fill == FILL_W'(TABLE_ENTRIES);
        insert       = !any_hit && !full;
        n_out_banned = |(hit & n_banned);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ban_threshold <= THRESHOLD_RESET;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_fill          <= '0;
            r_slot_valid    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ban_threshold <= i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && insert) begin
                r_fill <= r_fill + 1'b1;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (r_fill == FILL_W'(i)) begin
                        r_slot_valid[i] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_addr   <= i_req.source_address;
            r_in_second <= i_req.now_second;
        end
        if (advance) begin
            r_out_banned  <= n_out_banned;
            r_out_tracked <= any_hit || !full;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (hit[i]) begin
                    r_slot_count[i]  <= same_second[i] ? n_count[i] : COUNT_W'(1);
                    r_slot_second[i] <= r_in_second;
                    r_slot_banned[i] <= n_banned[i];
                end else if (insert && (r_fill == FILL_W'(i))) begin
                    r_slot_address[i] <= r_in_addr;
                    r_slot_count[i]   <= COUNT_W'(1);
                    r_slot_second[i]  <= r_in_second;
                    r_slot_banned[i]  <= 1'b0;
                end
            end
        end
    end

    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == 32'(r_fill))
        else $error("Fill level does not match the number of valid entries.");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(hit))
        else $error("A source address matches more than one table entry.");

    a_untracked_not_banned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_tracked) |-> !r_out_banned)
        else $error("An untracked source is reported as banned.");

    a_fill_moves_on_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance || any_hit) |=> $stable(r_fill))
        else $error("The fill level changed without an inserted source.");

endmodule

/* tb/per_source_request_rate_limiter_checker.sv */
// Checker that predicts every result word of the rate limiter and compares it with the block.
`timescale 1ns / 1ps

module per_source_request_rate_limiter_checker import psrl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    psrl_in_if                     i_req,
    psrl_out_if                    i_rsp,
    input  logic                   i_cfg_we,
    input  logic [THRESHOLD_W-1:0] i_cfg_wdata,
    output int                     o_pending,
    output int                     o_mismatches
);

    typedef struct packed {
        logic banned;
        logic tracked;
    } t_verdict;

    t_verdict               expected_verdicts[$];
    t_verdict               oldest;
    logic [THRESHOLD_W-1:0] ban_limit;
    logic                   entry_used   [TABLE_ENTRIES];
    t_addr                  entry_source [TABLE_ENTRIES];
    t_count                 entry_hits   [TABLE_ENTRIES];
    t_second                entry_second [TABLE_ENTRIES];
    logic                   entry_banned [TABLE_ENTRIES];
    int                     entries_taken;

    function automatic t_verdict rate_verdict(t_addr source, t_second second);
        int       hit;
        t_verdict verdict;
        hit     = -1;
        verdict = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && entry_used[i] && entry_source[i] == source) begin
                hit = i;
            end
        end
        if (hit < 0) begin
            if (entries_taken < TABLE_ENTRIES) begin
                hit               = entries_taken;
                entry_used[hit]   = 1'b1;
                entry_source[hit] = source;
                entry_hits[hit]   = t_count'(1);
                entry_second[hit] = second;
                entry_banned[hit] = 1'b0;
                entries_taken++;
            end
        end else if (entry_second[hit] != second) begin
            entry_hits[hit]   = t_count'(1);
            entry_second[hit] = second;
            entry_banned[hit] = 1'b0;
        end else begin
            if (entry_hits[hit] != COUNT_MAX) begin
                entry_hits[hit]++;
            end
            if (entry_hits[hit] >= ban_limit) begin
                entry_banned[hit] = 1'b1;
            end
        end
        if (hit >= 0) begin
            verdict.tracked = 1'b1;
            verdict.banned  = entry_banned[hit];
        end
        return verdict;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: %s", $time, what);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ban_limit     = THRESHOLD_RESET;
            entries_taken = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                entry_used[i] = 1'b0;
            end
            expected_verdicts.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                ban_limit = i_cfg_wdata;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result word arrived with no request outstanding");
                end else begin
                    oldest = expected_verdicts.pop_front();
                    if (i_rsp.banned !== oldest.banned) begin
                        report_mismatch($sformatf("banned is %b, expected %b",
                                                  i_rsp.banned, oldest.banned));
                    end
                    if (i_rsp.tracked !== oldest.tracked) begin
                        report_mismatch($sformatf("tracked is %b, expected %b",
                                                  i_rsp.tracked, oldest.tracked));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_verdicts.push_back(rate_verdict(i_req.source_address,
                                                         i_req.now_second));
            end
            o_pending <= expected_verdicts.size();
        end
    end

endmodule

/* tb/per_source_request_rate_limiter_core_tb.sv */
// Top of the rate limiter testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module per_source_request_rate_limiter_core_tb import psrl_pkg::*; ();

    localparam int POOL_SIZE      = TABLE_ENTRIES + 8;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [THRESHOLD_W-1:0] cfg_wdata;
    int                     pending;
    int                     mismatches;
    int                     quiet_cycles = 0;
    int                     tx_idle_pct = 37;
    int                     rx_idle_pct = 59;
    int                     hold_off_left = 0;
    t_addr                  pool [POOL_SIZE];
    t_second                clock_now;

    psrl_in_if  req_ch ();
    psrl_out_if rsp_ch ();

    per_source_request_rate_limiter_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    per_source_request_rate_limiter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always #5 clk = ~clk;

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_off_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(t_addr source, t_second second);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.source_address <= source;
        req_ch.now_second     <= second;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic set_threshold(logic [THRESHOLD_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Bursts of one source within one second climb toward the ban; strangers and
    // interleaved sources break the runs up.
    task automatic random_traffic(int quota, int burst_max);
        int      sent;
        int      burst;
        int      pick;
        t_addr   source;
        t_second second;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 99) < 10) begin
                source = $urandom;
                burst  = 1;
            end else begin
                source = pool[$urandom_range(0, POOL_SIZE - 1)];
                burst  = $urandom_range(1, burst_max);
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                second = clock_now;
            end else if (pick < 80) begin
                clock_now++;
                second = clock_now;
            end else if (pick < 90) begin
                second = clock_now - $urandom_range(1, 3);
            end else begin
                second = $urandom;
            end
            repeat (burst) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_request(pool[$urandom_range(0, POOL_SIZE - 1)], second);
                    sent++;
                end
                send_request(source, second);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        t_addr   fresh;
        logic    clash;
        t_second burst_second;
        req_ch.valid          <= 1'b0;
        req_ch.source_address <= '0;
        req_ch.now_second     <= '0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;

        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            do begin
                fresh = $urandom;
                clash = 1'b0;
                for (int j = 0; j < i; j++) begin
                    if (pool[j] == fresh) begin
                        clash = 1'b1;
                    end
                end
            end while (clash);
            pool[i] = fresh;
        end
        clock_now = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The threshold after reset is 20; the source stays banned past it.
        repeat (21) send_request(pool[0], '0);
        send_request(pool[1], '1);
        send_request(pool[0], '1);

        // A threshold of one still lets the first word through; time running
        // backwards counts as a new second.
        set_threshold(THRESHOLD_W'(1));
        send_request(pool[2], 32'd7);
        send_request(pool[2], 32'd7);
        send_request(pool[2], 32'd3);

        set_threshold('0);
        send_request(pool[3], 32'd9);
        send_request(pool[3], 32'd9);

        // Raising the threshold within a second keeps a ban that is already set.
        set_threshold(THRESHOLD_W'(2));
        send_request(pool[1], '1);
        set_threshold(THRESHOLD_W'(100));
        send_request(pool[1], '1);
        send_request(pool[1], '0);

        // Every pool source once: the table fills and the last few stay untracked.
        set_threshold(THRESHOLD_W'(3));
        for (int i = 0; i < POOL_SIZE; i++) begin
            send_request(pool[i], $urandom);
        end
        random_traffic(290, 6);

        drain();
        tx_idle_pct = 59;
        rx_idle_pct = 37;
        set_threshold(THRESHOLD_W'(1));
        random_traffic(290, 4);
        drain();
        hold_off_left = 300;
        random_traffic(40, 4);

        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_threshold('1);
        burst_second = $urandom;
        repeat (40) send_request(pool[5], burst_second);
        set_threshold(THRESHOLD_W'($urandom_range(2, 8)));
        random_traffic(290, 10);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* per_source_request_rate_limiter_core.f */
src/psrl_pkg.sv
src/psrl_if.sv
src/per_source_request_rate_limiter_core.sv
tb/per_source_request_rate_limiter_checker.sv
tb/per_source_request_rate_limiter_core_tb.sv
